FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the k-subset mask enumerator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define KSME_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define KSME_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ksme_pkg.sv
// ----------------------------------------------------------------------------
// ksme_pkg
// types and fixed widths shared by the k-subset mask enumerator modules
// ----------------------------------------------------------------------------
package ksme_pkg;

  localparam int MASK_W = 15;
  localparam int IDX_W  = 13;
  localparam int K_W    = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SNAP,
    S_SCAN,
    S_FILL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic snap;
    logic wrap;
    logic scan_dec;
    logic pivot;
    logic fill;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic k_zero;
    logic scan_hit;
    logic scan_zero;
    logic fill_done;
    logic out_free;
  } sts_t;

endpackage

FILE: design/ksme_ctrl.sv
// ----------------------------------------------------------------------------
// ksme_ctrl
// sequencer: snapshot, pivot scan from the right, refill, then hand off
// ----------------------------------------------------------------------------
module ksme_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ksme_pkg::sts_t sts,
  output ksme_pkg::cmd_t cmd
);

  ksme_pkg::state_t state;
  ksme_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ksme_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ksme_pkg::S_IDLE: begin
        if (in_valid) state_next = ksme_pkg::S_SNAP;
      end
      ksme_pkg::S_SNAP: begin
        state_next = sts.k_zero ? ksme_pkg::S_EMIT : ksme_pkg::S_SCAN;
      end
      ksme_pkg::S_SCAN: begin
        if (sts.scan_hit) state_next = ksme_pkg::S_FILL;
        else if (sts.scan_zero) state_next = ksme_pkg::S_EMIT;
      end
      ksme_pkg::S_FILL: begin
        if (sts.fill_done) state_next = ksme_pkg::S_EMIT;
      end
      ksme_pkg::S_EMIT: begin
        if (sts.out_free) state_next = ksme_pkg::S_IDLE;
      end
      default: state_next = ksme_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ksme_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ksme_pkg::S_SNAP: begin
        cmd.snap = 1'b1;
        // no ones: nothing can advance, the single mask is also the last
        cmd.wrap = sts.k_zero;
      end
      ksme_pkg::S_SCAN: begin
        if (sts.scan_hit) cmd.pivot = 1'b1;
        else if (sts.scan_zero) cmd.wrap = 1'b1;
        else cmd.scan_dec = 1'b1;
      end
      ksme_pkg::S_FILL: begin
        cmd.fill = !sts.fill_done;
      end
      ksme_pkg::S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/ksme_dp.sv
// ----------------------------------------------------------------------------
// ksme_dp
// position registers, running index, scan/fill pointers and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksme_dp #(
  parameter int N_ITEMS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ksme_pkg::K_W-1:0]      ones_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ksme_pkg::MASK_W-1:0]   selection_mask,
  output logic [ksme_pkg::IDX_W-1:0]    combination_index,
  output logic                          cycle_end,
  input  ksme_pkg::cmd_t                cmd,
  output ksme_pkg::sts_t                sts
);

  localparam int PW = $clog2(N_ITEMS);
  localparam int FW = PW + 1;
  localparam int CW = ((FW > ksme_pkg::K_W) ? FW : ksme_pkg::K_W) + 1;
  localparam int XW = (N_ITEMS > ksme_pkg::MASK_W) ? N_ITEMS : ksme_pkg::MASK_W;

  logic [ksme_pkg::K_W-1:0]    ones_cnt;
  logic [ksme_pkg::K_W-1:0]    k_eff;
  logic [PW-1:0]               pos [N_ITEMS];
  logic [ksme_pkg::IDX_W-1:0]  run_idx;
  logic [PW-1:0]               scan_ptr;
  logic [FW-1:0]               fill_ptr;
  logic [FW-1:0]               fill_val;
  logic [PW-1:0]               pos_sel;
  logic [CW-1:0]               limit;
  logic [N_ITEMS-1:0]          mask_now;
  logic [XW-1:0]               mask_ext;
  logic [ksme_pkg::MASK_W-1:0] mask_hold;
  logic [ksme_pkg::IDX_W-1:0]  idx_hold;
  logic                        end_hold;
  logic                        cfg_we;
  logic                        load_first;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid & cfg_ready;
  assign load_first = cfg_we | (cmd.accept & restart) | cmd.wrap;

  // k saturates at the item count
  assign k_eff = (CW'(ones_cnt) > CW'(N_ITEMS)) ? ksme_pkg::K_W'(N_ITEMS) : ones_cnt;

  assign pos_sel = pos[scan_ptr];
  // highest value slot s may hold and still leave room for the slots after it
  assign limit   = CW'(N_ITEMS) - CW'(k_eff) + CW'(scan_ptr);

  always_comb begin
    mask_now = '0;
    for (int i = 0; i < N_ITEMS; i++) begin
      if (CW'(i) < CW'(k_eff)) mask_now = mask_now | (N_ITEMS'(1) << pos[i]);
    end
  end

  assign mask_ext = XW'(mask_now);

  assign sts.k_zero    = (k_eff == '0);
  assign sts.scan_hit  = CW'(pos_sel) < limit;
  assign sts.scan_zero = (scan_ptr == '0);
  assign sts.fill_done = CW'(fill_ptr) >= CW'(k_eff);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_cnt  <= ksme_pkg::K_W'(1);
      run_idx   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < N_ITEMS; i++) begin
        pos[i] <= PW'(i);
      end
    end else begin
      if (cfg_we) ones_cnt <= ones_count;
      if (load_first) begin
        run_idx <= '0;
        for (int i = 0; i < N_ITEMS; i++) begin
          pos[i] <= PW'(i);
        end
      end
      if (cmd.pivot) begin
        pos[scan_ptr] <= pos_sel + PW'(1);
        run_idx       <= run_idx + ksme_pkg::IDX_W'(1);
      end
      if (cmd.fill) pos[fill_ptr[PW-1:0]] <= fill_val[PW-1:0];
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      mask_hold <= mask_ext[ksme_pkg::MASK_W-1:0];
      idx_hold  <= run_idx;
      end_hold  <= sts.k_zero;
      scan_ptr  <= sts.k_zero ? '0 : PW'(k_eff - ksme_pkg::K_W'(1));
    end
    if (cmd.wrap && !cmd.snap) end_hold <= 1'b1;
    if (cmd.scan_dec) scan_ptr <= scan_ptr - PW'(1);
    if (cmd.pivot) begin
      fill_val <= FW'(pos_sel) + FW'(2);
      fill_ptr <= FW'(scan_ptr) + FW'(1);
    end
    if (cmd.fill) begin
      fill_val <= fill_val + FW'(1);
      fill_ptr <= fill_ptr + FW'(1);
    end
    if (cmd.emit) begin
      selection_mask    <= mask_hold;
      combination_index <= idx_hold;
      cycle_end         <= end_hold;
    end
  end

  `KSME_ASSERT_NOW(a_fill_in_range, clk, rst, cmd.fill, CW'(fill_ptr) < CW'(k_eff), "fill past k")
  `KSME_ASSERT_NOW(a_pivot_in_range, clk, rst, cmd.pivot, CW'(scan_ptr) < CW'(k_eff), "pivot past k")
  `KSME_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, sts.out_free, "emit over a held word")
  `KSME_ASSERT_NEXT(a_wrap_clears, clk, rst, cmd.wrap, run_idx == '0, "index not cleared on wrap")

endmodule

FILE: design/k_subset_mask_enumerator.sv
// ----------------------------------------------------------------------------
// k_subset_mask_enumerator
// steps through all k-of-N selection masks in lexicographic order
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready, restart): each word asks for one mask;
// restart set returns to the first combination before the mask is made.
// output channel (out_valid/out_ready): selection_mask, combination_index
// and cycle_end, which marks the last mask before the walk wraps.
// config channel (cfg_valid/cfg_ready, ones_count): sets k, always ready,
// and sends the walk back to the first combination. write only when idle.
// the time from accept to output is set by the pivot scan, which reads one
// position per cycle from the right, and by the refill, one slot per cycle;
// a wrap skips the refill and k = 0 skips both.
// the next word is taken the cycle after its result is loaded into the
// output register, even while that result still waits for out_ready, so
// the block never takes a new word while one is still in work.
// a stalled receiver holds the output register; the sequencer waits in its
// hand-off state until the register frees up.
// reset: k = 1, positions at the first combination, index zero, no output.
// ----------------------------------------------------------------------------
module k_subset_mask_enumerator #(
  parameter int N_ITEMS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          restart,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ksme_pkg::K_W-1:0]      ones_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ksme_pkg::MASK_W-1:0]   selection_mask,
  output logic [ksme_pkg::IDX_W-1:0]    combination_index,
  output logic                          cycle_end
);

  ksme_pkg::cmd_t cmd;
  ksme_pkg::sts_t sts;

  ksme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ksme_dp #(
    .N_ITEMS (N_ITEMS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .restart           (restart),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .ones_count        (ones_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .selection_mask    (selection_mask),
    .combination_index (combination_index),
    .cycle_end         (cycle_end),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
